[rtl/ssca_pkg.sv]
`timescale 1ns / 1ps
package ssca_pkg;

    localparam int POOL_PAGES    = 64;
    localparam int PAGE_BYTES    = 4096;
    localparam int CLASS_COUNT   = 10;
    localparam int GRAN_PER_PAGE = PAGE_BYTES / 8;
    localparam int GRAN_TOTAL    = POOL_PAGES * GRAN_PER_PAGE;
    localparam int GRAN_W        = $clog2(GRAN_TOTAL);
    localparam int LINK_W        = 16;
    localparam int PAGE_W        = $clog2(POOL_PAGES);
    localparam int CLS_W         = 4;
    localparam int ADDR_W        = 48;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_TOO_BIG  = 3'd1;
    localparam logic [2:0] ST_EXHAUST  = 3'd2;
    localparam logic [2:0] ST_NULL     = 3'd3;
    localparam logic [2:0] ST_PAGE     = 3'd4;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    typedef struct packed {
        logic        operation;
        logic [12:0] request_bytes;
        logic [47:0] free_address;
    } t_in_item;

    typedef struct packed {
        logic [47:0] object_address;
        logic [3:0]  size_class;
        logic [2:0]  status;
    } t_out_item;

    // slot size in 8-byte granules
    function automatic logic [7:0] class_step(input logic [CLS_W-1:0] c);
        logic [7:0] s;
        unique case (c)
            4'd0: s = 8'd1;
            4'd1: s = 8'd2;
            4'd2: s = 8'd3;
            4'd3: s = 8'd4;
            4'd4: s = 8'd6;
            4'd5: s = 8'd8;
            4'd6: s = 8'd16;
            4'd7: s = 8'd32;
            4'd8: s = 8'd64;
            4'd9: s = 8'd128;
            default: s = 8'd1;
        endcase
        return s;
    endfunction

    // slots per page excluding header
    function automatic logic [8:0] class_slots(input logic [CLS_W-1:0] c);
        logic [8:0] n;
        unique case (c)
            4'd0: n = 9'd511;
            4'd1: n = 9'd255;
            4'd2: n = 9'd169;
            4'd3: n = 9'd127;
            4'd4: n = 9'd84;
            4'd5: n = 9'd63;
            4'd6: n = 9'd31;
            4'd7: n = 9'd15;
            4'd8: n = 9'd7;
            4'd9: n = 9'd3;
            default: n = 9'd1;
        endcase
        return n;
    endfunction

    // first class with bytes >= need; CLASS_COUNT when none
    function automatic logic [CLS_W-1:0] pick_class(input logic [13:0] need);
        logic [CLS_W-1:0] c;
        if (need <= 14'd8)         c = 4'd0;
        else if (need <= 14'd16)   c = 4'd1;
        else if (need <= 14'd24)   c = 4'd2;
        else if (need <= 14'd32)   c = 4'd3;
        else if (need <= 14'd48)   c = 4'd4;
        else if (need <= 14'd64)   c = 4'd5;
        else if (need <= 14'd128)  c = 4'd6;
        else if (need <= 14'd256)  c = 4'd7;
        else if (need <= 14'd512)  c = 4'd8;
        else if (need <= 14'd1024) c = 4'd9;
        else                       c = 4'd10;
        return c;
    endfunction

endpackage

[rtl/slab_size_class_allocator_top.sv]
`timescale 1ns / 1ps
// Slab allocator with ten size classes over a pool of 4 KiB pages.
// Input channel: i_in_valid / o_in_stall with an allocate or free request.
// Output channel: o_out_valid / i_out_stall with one result per request.
// Configuration through an APB-style port: pool_base at 0x0, pool_pages_used
// at 0x8 (64-bit data); pready is always high, reads return the registers.
// The slot links live in a 32K-entry synchronous RAM, page classes in a
// 64-entry RAM; class list heads are flip-flops.
// A pop or a push passes through decode, RAM read, RAM write/update and
// result states before the result is valid. An allocation that finds its
// list empty first builds a fresh page, one RAM write per slot, for up to
// 511 slots (3 for the 1024-byte class).
// One request is in flight at a time; the next is taken once the result
// register has been handed off or while it is being taken, so a new request
// is not taken before the last one's result has been registered.
// Reset empties all lists and the page counter; no clearing pass is run,
// since link and class entries are written before they are ever read.
// A stalled result holds in the output register and blocks new requests.
module slab_size_class_allocator_top (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_stall,
    input  ssca_pkg::t_in_item        i_in_data,
    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output ssca_pkg::t_out_item       o_out_data,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [3:0]                paddr,
    input  logic [63:0]               pwdata,
    output logic [63:0]               prdata,
    output logic                      pready
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_DEC   = 3'd1;
    localparam logic [2:0] S_BUILD = 3'd2;
    localparam logic [2:0] S_READ  = 3'd3;
    localparam logic [2:0] S_POP   = 3'd4;
    localparam logic [2:0] S_OUT   = 3'd5;

    localparam logic [3:0] A_BASE  = 4'h0;
    localparam logic [3:0] A_PAGES = 4'h8;

    localparam int GW = ssca_pkg::GRAN_W;
    localparam int LW = ssca_pkg::LINK_W;
    localparam int PW = ssca_pkg::PAGE_W;
    localparam int CW = ssca_pkg::CLS_W;

    logic [47:0] r_base;
    logic [6:0]  r_pages_used;

    logic [LW-1:0] r_head [ssca_pkg::CLASS_COUNT];
    logic [PW:0]   r_next_page;

    logic [LW-1:0] link_mem [ssca_pkg::GRAN_TOTAL];
    logic [CW-1:0] pcls_mem [ssca_pkg::POOL_PAGES];
    logic [LW-1:0] r_link_rd;
    logic [CW-1:0] r_pcls_rd;

    logic [2:0]          r_state;
    ssca_pkg::t_in_item  r_req;
    ssca_pkg::t_out_item r_out;
    logic                r_out_valid;
    logic [CW-1:0]       r_cls;
    logic [GW-1:0]       r_gran;
    logic [8:0]          r_bcnt;
    logic [GW-1:0]       r_bgran;

    logic        cfg_wr;
    logic        in_xfer;
    logic        out_free;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_comb begin
        unique case (paddr)
            A_BASE:  prdata = {16'd0, r_base};
            A_PAGES: prdata = {57'd0, r_pages_used};
            default: prdata = 64'd0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base       <= '0;
            r_pages_used <= 7'd64;
        end else if (cfg_wr) begin
            if (paddr == A_BASE)  r_base       <= pwdata[47:0];
            if (paddr == A_PAGES) r_pages_used <= pwdata[6:0];
        end
    end

    assign out_free    = !r_out_valid || !i_out_stall;
    // hold off while a stalled result still sits in the output register
    assign o_in_stall  = (r_state != S_IDLE) || (r_out_valid && i_out_stall);
    assign in_xfer     = i_in_valid && !o_in_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // free decode
    logic [47:0] f_off;
    logic [PW:0] f_page_full;
    logic        f_hi_ok;
    logic [PW-1:0] f_page;
    logic [GW-1:0] f_gran;
    assign f_off       = r_req.free_address - r_base;
    assign f_hi_ok     = (f_off[47:12+PW] == '0);
    assign f_page_full = {1'b0, f_off[12 +: PW]};
    assign f_page      = f_off[12 +: PW];
    assign f_gran      = f_off[3 +: GW];

    logic [CW-1:0] a_cls;
    logic [PW:0]   usable;
    assign a_cls  = ssca_pkg::pick_class({1'b0, r_req.request_bytes} + 14'd8);
    assign usable = (r_pages_used > 7'(ssca_pkg::POOL_PAGES))
                    ? (PW+1)'(ssca_pkg::POOL_PAGES) : (PW+1)'(r_pages_used);

    logic [7:0] b_step;
    assign b_step = ssca_pkg::class_step(r_cls);

    // link RAM port: single write, single read
    logic          lk_we;
    logic [GW-1:0] lk_wa;
    logic [LW-1:0] lk_wd;
    logic [GW-1:0] lk_ra;

    always_comb begin
        lk_we = 1'b0;
        lk_wa = r_gran;
        lk_wd = r_head[r_cls];
        lk_ra = r_gran;
        if (r_state == S_BUILD) begin
            lk_we = 1'b1;
            lk_wa = r_bgran;
            lk_wd = (r_bcnt == 9'd1) ? '0 : LW'(r_bgran + GW'(b_step) + GW'(1));
        end else if (r_state == S_POP && r_req.operation == ssca_pkg::OP_FREE) begin
            lk_we = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (lk_we) link_mem[lk_wa] <= lk_wd;
        r_link_rd <= link_mem[lk_ra];
    end

    logic pc_we;
    assign pc_we = (r_state == S_DEC) && (r_req.operation == ssca_pkg::OP_ALLOC)
                   && (a_cls != 4'd10) && (r_head[a_cls] == '0) && (r_next_page < usable);

    always_ff @(posedge i_clk) begin
        if (pc_we) pcls_mem[r_next_page[PW-1:0]] <= a_cls;
        r_pcls_rd <= pcls_mem[f_page];
    end

    logic [GW-1:0] pop_g;
    assign pop_g = GW'(r_head[r_cls] - LW'(1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_next_page <= '0;
            for (int k = 0; k < ssca_pkg::CLASS_COUNT; k++) r_head[k] <= '0;
        end else begin
            if (r_out_valid && !i_out_stall) r_out_valid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (in_xfer) begin
                        r_req   <= i_in_data;
                        r_state <= S_DEC;
                    end
                end
                S_DEC: begin
                    r_out.object_address <= '0;
                    r_out.size_class     <= '0;
                    r_out.status         <= ssca_pkg::ST_OK;
                    r_state              <= S_OUT;
                    if (r_req.operation == ssca_pkg::OP_ALLOC) begin
                        if (a_cls == 4'd10) begin
                            r_out.status <= ssca_pkg::ST_TOO_BIG;
                        end else begin
                            r_cls            <= a_cls;
                            r_out.size_class <= a_cls;
                            if (r_head[a_cls] != '0) begin
                                r_gran  <= GW'(r_head[a_cls] - LW'(1));
                                r_state <= S_READ;
                            end else if (r_next_page < usable) begin
                                r_bgran <= GW'({r_next_page[PW-1:0], 9'd0})
                                           + GW'(ssca_pkg::class_step(a_cls));
                                r_bcnt  <= ssca_pkg::class_slots(a_cls);
                                r_next_page <= r_next_page + 1'b1;
                                r_state <= S_BUILD;
                            end else begin
                                r_out.status <= ssca_pkg::ST_EXHAUST;
                            end
                        end
                    end else begin
                        if (r_req.free_address == '0) begin
                            r_out.status <= ssca_pkg::ST_NULL;
                        end else if (r_req.free_address[11:0] == 12'd0
                                     || r_req.free_address < r_base || !f_hi_ok
                                     || f_page_full >= r_next_page) begin
                            r_out.status <= ssca_pkg::ST_PAGE;
                        end else begin
                            r_gran  <= f_gran;
                            r_state <= S_READ;
                        end
                    end
                end
                S_BUILD: begin
                    r_bgran <= r_bgran + GW'(b_step);
                    r_bcnt  <= r_bcnt - 9'd1;
                    if (r_bcnt == 9'd1) begin
                        r_head[r_cls] <= LW'({r_next_page - 1'b1, 9'd0})
                                         + LW'(b_step) + LW'(1);
                        r_gran  <= GW'({r_next_page - 1'b1, 9'd0}) + GW'(b_step);
                        r_state <= S_READ;
                    end
                end
                S_READ: begin
                    // page class RAM read was issued last cycle; the link read is issued here
                    if (r_req.operation == ssca_pkg::OP_FREE) begin
                        r_cls <= (r_pcls_rd >= 4'd10) ? '0 : r_pcls_rd;
                    end
                    r_state <= S_POP;
                end
                S_POP: begin
                    if (r_req.operation == ssca_pkg::OP_ALLOC) begin
                        r_head[r_cls]        <= r_link_rd;
                        r_out.object_address <= r_base + {{(45-GW){1'b0}}, pop_g, 3'd0};
                    end else begin
                        r_head[r_cls]    <= LW'(r_gran) + LW'(1);
                        r_out.size_class <= r_cls;
                    end
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule
